[rtl/ffba_pkg.sv]
// Shared types and constants for the first-fit block allocator.
// Used by ffba_ctrl, ffba_dp and first_fit_block_allocator; no dependencies.
`default_nettype none
package ffba_pkg;

    localparam int HEAP_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 24;
    localparam logic [12:0] LIMIT_RESET = 13'd4096;

    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_RESIZE = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NULL = 2'd1;
    localparam logic [1:0] ST_OOM  = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_NULL, OP_RD_H, OP_GOT, OP_SPAN_T, OP_ADV,
        OP_WR_SPLIT, OP_WR_CLAIM, OP_EXTEND, OP_OOM, OP_COPY, OP_RES_A,
        OP_OLD, OP_F_RDH, OP_F_GOT, OP_F_ADD, OP_F_WR, OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       size_zero;
        logic       a_ok;
        logic       walk_done;
        logic       fit;
        logic       merge;
        logic       split;
        logic       oom;
        logic       old_fits;
        logic       f_merge;
    } flags_t;

endpackage
`default_nettype wire

[rtl/first_fit_block_allocator.sv]
// Top level of the first-fit block allocator: controller plus datapath.
// Depends on ffba_pkg, ffba_ctrl and ffba_dp.
//
//   channel   ports                                          handshake
//   request   s_req_type, s_req_size, s_req_address          s_valid / s_ready
//   result    m_status, m_result_address, m_copy_*           m_valid / m_ready
//   config    cfg_wdata (heap limit)                         cfg_we
//
// One word at a time. Allocate walks the block headers through the single-port
// header memory until a block fits or the break is reached.
// Resize adds a header read and, when it moves, a free pass.
// Reset clears the break and restores the limit; headers are not cleared.
// A result waiting on m_ready stalls the next request only at its end.
`default_nettype none
module first_fit_block_allocator #(
    parameter int HEAP_BYTES   = ffba_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [12:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [11:0] s_req_size,
    input  wire logic [11:0] s_req_address,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_status,
    output logic [11:0]      m_result_address,
    output logic             m_copy_needed,
    output logic [11:0]      m_copy_source,
    output logic [11:0]      m_copy_length
);
    import ffba_pkg::*;

    cmd_t   cmd;
    flags_t flags;

    ffba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .flags   (flags),
        .cmd     (cmd)
    );

    ffba_dp #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .flags            (flags),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .s_req_type       (s_req_type),
        .s_req_size       (s_req_size),
        .s_req_address    (s_req_address),
        .m_status         (m_status),
        .m_result_address (m_result_address),
        .m_copy_needed    (m_copy_needed),
        .m_copy_source    (m_copy_source),
        .m_copy_length    (m_copy_length)
    );

endmodule
`default_nettype wire

[rtl/ffba_ctrl.sv]
// Sequencer for the allocator: walks allocate, free and resize steps.
// Depends on ffba_pkg; drives ffba_dp through cmd_t and reads flags_t.
`default_nettype none
module ffba_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    input  wire ffba_pkg::flags_t flags,
    output ffba_pkg::cmd_t       cmd
);
    import ffba_pkg::*;

    typedef enum logic [3:0] {
        IDLE, DISP, A_CHK, A_GOT, A_DEC, A_CLAIM, A_CLAIM2, A_EXT, A_FIN,
        F_RD, F_GOT, F_DEC, F_WR, R_GOT, DONE
    } state_t;

    state_t state_reg, state_next;
    logic   move_reg, move_next;
    logic   valid_reg, valid_next;

    assign s_ready = (state_reg == IDLE);
    assign m_valid = valid_reg;

    always_comb begin
        state_next = state_reg;
        move_next  = move_reg;
        valid_next = valid_reg & ~m_ready;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = DISP;
                end
            end
            DISP: begin
                move_next = 1'b0;
                priority if (flags.req_type == REQ_FREE) begin
                    state_next = flags.a_ok ? F_RD : DONE;
                end else if (flags.req_type == REQ_RESIZE && flags.a_ok) begin
                    move_next  = 1'b1;
                    state_next = F_RD;
                end else if (flags.req_type == REQ_ALLOC
                             || flags.req_type == REQ_RESIZE) begin
                    if (flags.size_zero) begin
                        cmd.op     = OP_NULL;
                        state_next = DONE;
                    end else begin
                        state_next = A_CHK;
                    end
                end else begin
                    state_next = DONE;
                end
            end
            A_CHK: begin
                if (flags.walk_done) begin
                    state_next = A_EXT;
                end else begin
                    cmd.op     = OP_RD_H;
                    state_next = A_GOT;
                end
            end
            A_GOT: begin
                cmd.op     = OP_GOT;
                state_next = A_DEC;
            end
            A_DEC: begin
                priority if (flags.fit) begin
                    state_next = A_CLAIM;
                end else if (flags.merge) begin
                    cmd.op     = OP_SPAN_T;
                    state_next = A_CLAIM;
                end else begin
                    cmd.op     = OP_ADV;
                    state_next = A_CHK;
                end
            end
            A_CLAIM: begin
                if (flags.split) cmd.op = OP_WR_SPLIT;
                state_next = A_CLAIM2;
            end
            A_CLAIM2: begin
                cmd.op     = OP_WR_CLAIM;
                state_next = A_FIN;
            end
            A_EXT: begin
                if (flags.oom) begin
                    cmd.op     = OP_OOM;
                    state_next = DONE;
                end else begin
                    cmd.op     = OP_EXTEND;
                    state_next = A_FIN;
                end
            end
            A_FIN: begin
                if (move_reg) begin
                    cmd.op     = OP_COPY;
                    move_next  = 1'b0;
                    state_next = F_RD;
                end else begin
                    state_next = DONE;
                end
            end
            F_RD: begin
                cmd.op     = OP_F_RDH;
                state_next = move_reg ? R_GOT : F_GOT;
            end
            R_GOT: begin
                // old block large enough: keep it
                if (flags.old_fits) begin
                    cmd.op     = OP_RES_A;
                    state_next = DONE;
                end else begin
                    cmd.op     = OP_OLD;
                    state_next = A_CHK;
                end
            end
            F_GOT: begin
                cmd.op     = OP_F_GOT;
                state_next = F_DEC;
            end
            F_DEC: begin
                if (flags.f_merge) cmd.op = OP_F_ADD;
                state_next = F_WR;
            end
            F_WR: begin
                cmd.op     = OP_F_WR;
                state_next = DONE;
            end
            DONE: begin
                // hold the result until the output register is free
                if (!valid_reg || m_ready) begin
                    cmd.op     = OP_OUT;
                    valid_next = 1'b1;
                    state_next = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
            move_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            move_reg  <= move_next;
            valid_reg <= valid_next;
        end
    end

endmodule
`default_nettype wire

[rtl/ffba_dp.sv]
// Datapath for the allocator: header memory, break, walk and result registers.
// Depends on ffba_pkg; steered by ffba_ctrl.
`default_nettype none
module ffba_dp #(
    parameter int HEAP_BYTES   = ffba_pkg::HEAP_BYTES_DEF,
    parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire ffba_pkg::cmd_t   cmd,
    output ffba_pkg::flags_t      flags,
    input  wire logic             cfg_we,
    input  wire logic [12:0]      cfg_wdata,
    input  wire logic [1:0]       s_req_type,
    input  wire logic [11:0]      s_req_size,
    input  wire logic [11:0]      s_req_address,
    output logic [1:0]            m_status,
    output logic [11:0]           m_result_address,
    output logic                  m_copy_needed,
    output logic [11:0]           m_copy_source,
    output logic [11:0]           m_copy_length
);
    import ffba_pkg::*;

    localparam int AW = $clog2(HEAP_BYTES);
    localparam int WW = ((AW > 12) ? AW : 12) + 2;
    localparam logic [WW-1:0] HDR   = WW'(HEADER_BYTES);
    localparam logic [WW-1:0] HEAPW = WW'(HEAP_BYTES);

    logic [AW:0]   mem [HEAP_BYTES];   // {used, size}
    logic [AW:0]   rd_reg;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [AW:0]   wr_data;
    logic          rd_en, wr_en;

    logic [1:0]    type_reg;
    logic [11:0]   size_reg, a_reg;
    logic [WW-1:0] h_reg, s_reg, span_reg, fs_reg;
    logic          u_reg;
    logic [AW:0]   brk_reg;
    logic [12:0]   lim_reg;
    logic [AW-1:0] old_reg;
    logic [1:0]    st_reg;
    logic [11:0]   res_reg, src_reg, len_reg;
    logic          cp_reg;

    logic [WW-1:0] sz, aw, brk, rds, lim, n_addr, split_addr;
    logic          rd_used;

    function automatic logic [AW-1:0] rd_addr_next(input logic [WW-1:0] v);
        return v[AW-1:0];
    endfunction

    assign sz      = WW'(size_reg);
    assign aw      = WW'(a_reg);
    assign brk     = WW'(brk_reg);
    assign rds     = WW'(rd_reg[AW-1:0]);
    assign rd_used = rd_reg[AW];
    assign lim     = (WW'(lim_reg) < HEAPW) ? WW'(lim_reg) : HEAPW;
    assign n_addr  = h_reg + HDR + s_reg;
    assign split_addr = h_reg + HDR + sz;

    always_comb begin
        flags.req_type  = type_reg;
        flags.size_zero = (size_reg == 12'd0);
        flags.a_ok      = (aw != '0) && (aw >= HDR) && ((aw - HDR) < brk);
        flags.walk_done = !((h_reg < brk) && (h_reg < HEAPW));
        flags.fit       = !u_reg && (s_reg >= sz);
        flags.merge     = !u_reg && (n_addr < brk) && !rd_used && (sz <= s_reg + HDR + rds);
        flags.split     = (span_reg - sz) >= (HDR + WW'(1));
        flags.oom       = (brk + HDR + sz) > lim;
        flags.old_fits  = rds >= sz;
        flags.f_merge   = ((aw + fs_reg) < brk) && !rd_used;
    end

    // single memory port: steer address and data per step
    always_comb begin
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        rd_addr = h_reg[AW-1:0];
        wr_addr = h_reg[AW-1:0];
        wr_data = '0;
        unique case (cmd.op)
            OP_RD_H:  rd_en = 1'b1;
            OP_GOT: begin
                rd_en   = 1'b1;
                rd_addr = rd_addr_next(h_reg + HDR + rds);
            end
            OP_F_RDH: begin
                rd_en   = 1'b1;
                rd_addr = rd_addr_next(aw - HDR);
            end
            OP_F_GOT: begin
                rd_en   = 1'b1;
                rd_addr = rd_addr_next(aw + rds);
            end
            OP_WR_SPLIT: begin
                wr_en   = split_addr < HEAPW;
                wr_addr = split_addr[AW-1:0];
                wr_data = {1'b0, AW'(span_reg - sz - HDR)};
            end
            OP_WR_CLAIM: begin
                wr_en   = 1'b1;
                wr_data = {1'b1, flags.split ? AW'(sz) : AW'(span_reg)};
            end
            OP_EXTEND: begin
                wr_en   = 1'b1;
                wr_addr = brk_reg[AW-1:0];
                wr_data = {1'b1, AW'(sz)};
            end
            OP_F_WR: begin
                wr_en   = 1'b1;
                wr_addr = rd_addr_next(aw - HDR);
                wr_data = {1'b0, AW'(fs_reg)};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brk_reg       <= '0;
            lim_reg       <= LIMIT_RESET;
        end else begin
            if (cfg_we) lim_reg <= cfg_wdata;
            if (cmd.op == OP_EXTEND) brk_reg <= (AW+1)'(brk + HDR + sz);
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                type_reg <= s_req_type;
                size_reg <= s_req_size;
                a_reg    <= s_req_address;
                h_reg    <= '0;
                st_reg   <= ST_OK;
                res_reg  <= '0;
                cp_reg   <= 1'b0;
                src_reg  <= '0;
                len_reg  <= '0;
            end
            OP_NULL:     st_reg <= ST_NULL;
            OP_OOM:      st_reg <= ST_OOM;
            OP_GOT: begin
                s_reg    <= rds;
                u_reg    <= rd_used;
                span_reg <= rds;
            end
            OP_SPAN_T:   span_reg <= s_reg + HDR + rds;
            OP_ADV:      h_reg <= n_addr;
            OP_WR_CLAIM: res_reg <= 12'(h_reg + HDR);
            OP_EXTEND:   res_reg <= 12'(brk + HDR);
            OP_COPY: begin
                cp_reg  <= 1'b1;
                src_reg <= a_reg;
                len_reg <= 12'(WW'(old_reg));
            end
            OP_RES_A:    res_reg <= a_reg;
            OP_OLD:      old_reg <= rd_reg[AW-1:0];
            OP_F_GOT:    fs_reg <= rds;
            OP_F_ADD:    fs_reg <= fs_reg + HDR + rds;
            OP_OUT: begin
                m_status         <= st_reg;
                m_result_address <= res_reg;
                m_copy_needed    <= cp_reg;
                m_copy_source    <= src_reg;
                m_copy_length    <= len_reg;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[tb/tb.sv]
// Testbench for first_fit_block_allocator: random and directed allocate, free and resize
// requests, checked against a heap predictor held in a small scoreboard class.
// Depends on ffba_pkg and the first_fit_block_allocator RTL.
`default_nettype none

typedef struct packed {
    logic [1:0]  status;
    logic [11:0] addr;
    logic        copy;
    logic [11:0] src;
    logic [11:0] len;
} alloc_word_t;

class heap_scoreboard;
    localparam int HEAP = 4096;
    localparam int HDR  = 24;

    int unsigned blk_size [HEAP];
    bit          blk_used [HEAP];
    int unsigned brk;
    int unsigned limit;
    int unsigned last_grant;
    int          errors;
    alloc_word_t expected_q [$];

    function new();
        brk = 0;
        limit = 4096;
        errors = 0;
        last_grant = 0;
    endfunction

    function void set_limit(int unsigned v);
        limit = v & 13'h1fff;
    endfunction

    function int unsigned size_at(int unsigned at);
        return at < HEAP ? blk_size[at] : 0;
    endfunction

    function bit used_at(int unsigned at);
        return at < HEAP ? blk_used[at] : 1'b0;
    endfunction

    function void put(int unsigned at, int unsigned sz, bit u);
        if (at < HEAP) begin
            blk_size[at] = sz;
            blk_used[at] = u;
        end
    endfunction

    function int unsigned claim(int unsigned h, int unsigned span, int unsigned sz);
        int unsigned keep;
        keep = span;
        if (span - sz >= HDR + 1) begin
            put(h + HDR + sz, span - sz - HDR, 1'b0);
            keep = sz;
        end
        put(h, keep, 1'b1);
        return h + HDR;
    endfunction

    function logic [1:0] grab(int unsigned sz, output int unsigned addr);
        int unsigned h, s, n, t, top;
        addr = 0;
        h = 0;
        while (h < brk && h < HEAP) begin
            s = blk_size[h];
            if (!blk_used[h]) begin
                if (s >= sz) begin
                    addr = claim(h, s, sz);
                    return ffba_pkg::ST_OK;
                end
                n = h + HDR + s;
                if (n < brk && !used_at(n)) begin
                    t = s + HDR + size_at(n);
                    if (sz <= t) begin
                        addr = claim(h, t, sz);
                        return ffba_pkg::ST_OK;
                    end
                end
            end
            h += HDR + s;
        end
        top = limit < HEAP ? limit : HEAP;
        if (brk + HDR + sz > top)
            return ffba_pkg::ST_OOM;
        put(brk, sz, 1'b1);
        addr = brk + HDR;
        brk += HDR + sz;
        return ffba_pkg::ST_OK;
    endfunction

    function bit addr_ok(int unsigned a);
        return a >= HDR && a - HDR < brk;
    endfunction

    function void release_blk(int unsigned a);
        int unsigned h, s, n;
        if (a == 0 || !addr_ok(a))
            return;
        h = a - HDR;
        s = size_at(h);
        n = a + s;
        if (n < brk && !used_at(n))
            s += HDR + size_at(n);
        put(h, s, 1'b0);
    endfunction

    // Note an accepted request word and queue the result it should produce.
    function void note_request(logic [1:0] kind, logic [11:0] sz, logic [11:0] a);
        alloc_word_t w;
        int unsigned res, old;
        w = '0;
        res = 0;
        if (kind == ffba_pkg::REQ_FREE) begin
            release_blk(a);
        end else if (kind == ffba_pkg::REQ_ALLOC ||
                     (kind == ffba_pkg::REQ_RESIZE && (a == 0 || !addr_ok(a)))) begin
            if (sz == 0)
                w.status = ffba_pkg::ST_NULL;
            else
                w.status = grab(sz, res);
        end else if (kind == ffba_pkg::REQ_RESIZE) begin
            old = size_at(a - HDR);
            if (old >= sz) begin
                res = a;
            end else begin
                w.status = grab(sz, res);
                if (w.status == ffba_pkg::ST_OK) begin
                    release_blk(a);
                    w.copy = 1'b1;
                    w.src = a;
                    w.len = old[11:0];
                end
            end
        end
        w.addr = res[11:0];
        last_grant = res;
        expected_q.push_back(w);
    endfunction

    function void report(string what, int unsigned got, int unsigned want);
        $display("mismatch: %s got %0d expected %0d", what, got, want);
        errors++;
    endfunction

    function void check_result(alloc_word_t got);
        alloc_word_t w;
        if (expected_q.size() == 0) begin
            report("unexpected word, status", got.status, 0);
            return;
        end
        w = expected_q.pop_front();
        if (got.status != w.status) report("status", got.status, w.status);
        if (got.addr != w.addr) report("result_address", got.addr, w.addr);
        if (got.copy != w.copy) report("copy_needed", got.copy, w.copy);
        if (got.src != w.src) report("copy_source", got.src, w.src);
        if (got.len != w.len) report("copy_length", got.len, w.len);
    endfunction

    // Pick a payload offset of a block that is on the current chain.
    function int unsigned live_addr();
        int unsigned h;
        int unsigned cands [$];
        h = 0;
        while (h < brk && h < HEAP) begin
            cands.push_back(h + HDR);
            h += HDR + blk_size[h];
        end
        if (cands.size() == 0)
            return 0;
        return cands[$urandom_range(cands.size() - 1)];
    endfunction

    // Pick an address that free ignores and resize treats as none.
    function int unsigned bad_addr();
        if (brk + HDR <= 4095 && $urandom_range(1))
            return $urandom_range(4095, brk + HDR);
        return $urandom_range(HDR - 1);
    endfunction
endclass

module tb;
    import ffba_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [12:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [11:0] s_req_size;
    logic [11:0] s_req_address;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_status;
    logic [11:0] m_result_address;
    logic        m_copy_needed;
    logic [11:0] m_copy_source;
    logic [11:0] m_copy_length;

    heap_scoreboard sb;
    int unsigned cycles;
    bit calm;

    first_fit_block_allocator uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_req_size(s_req_size),
        .s_req_address(s_req_address),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_result_address(m_result_address),
        .m_copy_needed(m_copy_needed), .m_copy_source(m_copy_source),
        .m_copy_length(m_copy_length)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 1500000) begin
            $display("status: fail");
            $finish;
        end
    end

    // Check the result word first, then note the request word.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_status, m_result_address, m_copy_needed,
                             m_copy_source, m_copy_length});
        if (aresetn && s_valid && s_ready)
            sb.note_request(s_req_type, s_req_size, s_req_address);
    end

    // Alternate stretches with random idling and stretches with none.
    initial begin
        calm = 1'b0;
        forever begin
            repeat ($urandom_range(400, 100)) @(negedge aclk);
            calm = 1'b1;
            repeat ($urandom_range(600, 200)) @(negedge aclk);
            calm = 1'b0;
        end
    end

    always @(negedge aclk)
        m_ready <= calm || ($urandom_range(99) >= 29);

    task automatic send(logic [1:0] kind, int unsigned sz, int unsigned a);
        // drop valid while idling; keep it high across back-to-back words
        while (!calm && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= kind;
        s_req_size <= sz[11:0];
        s_req_address <= a[11:0];
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_limit(int unsigned v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v[12:0];
        sb.set_limit(v);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic int unsigned rand_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5) return 0;
        if (r < 75) return $urandom_range(64, 1);
        if (r < 97) return $urandom_range(300, 1);
        return $urandom_range(4095, 2048);
    endfunction

    task automatic random_phase(int n);
        int unsigned r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 45)
                send(REQ_ALLOC, rand_size(), $urandom_range(4095));
            else if (r < 75)
                send(REQ_FREE, $urandom_range(4095),
                     $urandom_range(9) < 8 ? sb.live_addr() :
                     ($urandom_range(1) ? 0 : sb.bad_addr()));
            else if (r < 97)
                send(REQ_RESIZE, rand_size(),
                     $urandom_range(9) < 8 ? sb.live_addr() :
                     ($urandom_range(1) ? 0 : sb.bad_addr()));
            else
                send(REQ_UNKNOWN, $urandom_range(4095), $urandom_range(4095));
        end
    endtask

    initial begin
        int unsigned x, y, z;
        sb = new();
        cycles = 0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_req_type = REQ_ALLOC;
        s_req_size = '0;
        s_req_address = '0;
        m_ready = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: null, out of memory, split, merge, absorb, move, odd types.
        send(REQ_ALLOC, 0, 0);
        send(REQ_ALLOC, 4095, 4095);
        send(REQ_ALLOC, 10, 0); x = sb.last_grant;
        send(REQ_ALLOC, 10, 0); y = sb.last_grant;
        send(REQ_ALLOC, 10, 0); z = sb.last_grant;
        send(REQ_FREE, 0, x);
        send(REQ_FREE, 0, y);
        send(REQ_ALLOC, 30, 0);
        send(REQ_FREE, 0, x);
        send(REQ_ALLOC, 5, 0);
        send(REQ_RESIZE, 0, z);
        send(REQ_RESIZE, 200, z);
        send(REQ_RESIZE, 8, 5);
        send(REQ_RESIZE, 0, 0);
        send(REQ_FREE, 0, 0);
        send(REQ_FREE, 4095, 4000);
        send(REQ_FREE, 0, 3);
        send(REQ_UNKNOWN, 4095, 4095);
        send(REQ_ALLOC, 1, 0);
        write_limit(0);
        send(REQ_ALLOC, 1, 0);
        send(REQ_RESIZE, 4095, 0);
        write_limit(8191);
        send(REQ_ALLOC, 2048, 0);
        send(REQ_FREE, 0, sb.last_grant);

        random_phase(250);
        write_limit(1200);
        random_phase(150);
        write_limit(4096);
        random_phase(250);
        write_limit(600);
        random_phase(80);
        write_limit(5000);
        random_phase(100);

        drain();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

`default_nettype wire

[sim.f]
rtl/ffba_pkg.sv
rtl/ffba_ctrl.sv
rtl/ffba_dp.sv
rtl/first_fit_block_allocator.sv
tb/tb.sv
